// ===== hw/rtl/kncp_pkg.sv =====
// Shared constants, types and helpers of the keyword and number command parser.
package kncp_pkg;

   localparam int KEYWORD_LEN = 6;
   localparam int KW_BYTES    = 6;
   localparam int KW_WIDTH    = 8 * KW_BYTES;
   localparam int POS_WIDTH   = 3;

   localparam logic [KW_WIDTH-1:0] KEYWORD_RESET = 48'h2052_4544_4146;

   typedef enum logic [1:0] {
      PH_LISTEN  = 2'b01,
      PH_CAPTURE = 2'b10
   } phase_type;

   // Keyword byte at a match position; positions past the register read as zero.
   function automatic logic [7:0] keyword_byte(logic [KW_WIDTH-1:0] kw,
                                               logic [POS_WIDTH-1:0] pos);
      logic [7:0] b;
      b = 8'h00;
      if (int'(pos) < KW_BYTES) begin
         b = kw[{pos, 3'b000} +: 8];
      end
      return b;
   endfunction

endpackage

// ===== hw/rtl/kncp_convert.sv =====
// Two-character decimal conversion with leading blanks and an optional sign.
module kncp_convert (
   input  logic [7:0]        first_char,
   input  logic [7:0]        second_char,
   output logic signed [7:0] level
);

   function automatic logic is_blank(logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   logic [3:0] d0;
   logic [3:0] d1;
   logic [7:0] d0_x10;
   logic [7:0] pair;
   logic [7:0] single;

   assign d0     = 4'(first_char - 8'h30);
   assign d1     = 4'(second_char - 8'h30);
   assign d0_x10 = {1'b0, d0, 3'b000} + {3'b000, d0, 1'b0};
   assign pair   = d0_x10 + {4'h0, d1};
   assign single = {4'h0, d1};

   always_comb begin
      level = 8'sd0;
      if (is_blank(first_char)) begin
         // A second blank or a lone sign both leave nothing to convert.
         if (is_digit(second_char)) begin
            level = signed'(single);
         end
      end else if ((first_char == 8'h2B) || (first_char == 8'h2D)) begin
         if (is_digit(second_char)) begin
            level = (first_char == 8'h2D) ? signed'(8'h00 - single) : signed'(single);
         end
      end else if (is_digit(first_char)) begin
         if (is_digit(second_char)) begin
            level = signed'(pair);
         end else begin
            level = signed'({4'h0, d0});
         end
      end
   end

endmodule

// ===== hw/rtl/keyword_number_command_parser.sv =====
// An accepted byte is held in the input register ahead of the parse stage; a level is
// presented in the cycle after the second number byte is parsed.
// Throughput: one byte per cycle, set by the compare-and-convert stage behind the input
// register, while the output register does not hold an untaken level, which stalls input.
// Reset (synchronous, active high) empties both registers, returns to keyword
// listening at match position zero and loads the keyword register with "FADER ".
module keyword_number_command_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] rx_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic signed [7:0]             rsp_tdata,   // [7:0] level
   input  logic                          csr_wr_en,
   input  logic [kncp_pkg::KW_WIDTH-1:0] csr_wr_data
);

   logic [kncp_pkg::KW_WIDTH-1:0]  keyword_ff;
   logic                           s1_valid_ff;
   logic [7:0]                     s1_byte_ff;
   kncp_pkg::phase_type            phase_ff, phase_in;
   logic [kncp_pkg::POS_WIDTH-1:0] match_pos_ff, match_pos_in;
   logic                           char_count_ff, char_count_in;
   logic [7:0]                     first_char_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]              rsp_level_ff;

   logic                           advance;
   logic                           load_result;
   logic                           byte_hit;
   logic [kncp_pkg::POS_WIDTH:0]   pos_next;
   logic signed [7:0]              level;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign load_result = advance && (phase_ff == kncp_pkg::PH_CAPTURE) && char_count_ff;
   assign byte_hit    = (s1_byte_ff == kncp_pkg::keyword_byte(keyword_ff, match_pos_ff));
   assign pos_next    = {1'b0, match_pos_ff} + 1'b1;

   kncp_convert u_convert (
      .first_char  (first_char_ff),
      .second_char (s1_byte_ff),
      .level       (level)
   );

   always_comb begin
      phase_in      = phase_ff;
      match_pos_in  = match_pos_ff;
      char_count_in = char_count_ff;
      if (advance) begin
         case (phase_ff)
            kncp_pkg::PH_LISTEN: begin
               if (!byte_hit) begin
                  match_pos_in = '0;
               end else if (pos_next >= (kncp_pkg::POS_WIDTH+1)'(kncp_pkg::KEYWORD_LEN)) begin
                  match_pos_in  = '0;
                  phase_in      = kncp_pkg::PH_CAPTURE;
                  char_count_in = 1'b0;
               end else begin
                  match_pos_in = pos_next[kncp_pkg::POS_WIDTH-1:0];
               end
            end
            kncp_pkg::PH_CAPTURE: begin
               if (!char_count_ff) begin
                  char_count_in = 1'b1;
               end else begin
                  char_count_in = 1'b0;
                  match_pos_in  = '0;
                  phase_in      = kncp_pkg::PH_LISTEN;
               end
            end
            default: begin
               phase_in      = kncp_pkg::PH_LISTEN;
               match_pos_in  = '0;
               char_count_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keyword_ff    <= kncp_pkg::KEYWORD_RESET;
         s1_valid_ff   <= 1'b0;
         phase_ff      <= kncp_pkg::PH_LISTEN;
         match_pos_ff  <= '0;
         char_count_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            keyword_ff <= csr_wr_data;
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         phase_ff      <= phase_in;
         match_pos_ff  <= match_pos_in;
         char_count_ff <= char_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata;
      end
      if (advance && (phase_ff == kncp_pkg::PH_CAPTURE) && !char_count_ff) begin
         first_char_ff <= s1_byte_ff;
      end
      if (load_result) begin
         rsp_level_ff <= level;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;

`ifndef SYNTHESIS
   // The capture counter only runs while the number is being captured.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == kncp_pkg::PH_LISTEN) |-> !char_count_ff)
      else $error("capture count set while listening for the keyword");

   // The match position never reaches the keyword length.
   assert property (@(posedge clock) disable iff (reset)
      int'(match_pos_ff) < kncp_pkg::KEYWORD_LEN)
      else $error("match position out of range");

   // A result goes back to listening from position zero.
   assert property (@(posedge clock) disable iff (reset)
      load_result |=> (phase_ff == kncp_pkg::PH_LISTEN) && (match_pos_ff == '0))
      else $error("parser did not return to listening after a result");

   // A new level is only loaded into a free or draining output register.
   assert property (@(posedge clock) disable iff (reset)
      load_result |-> (!rsp_valid_ff || rsp_tready))
      else $error("untaken level overwritten");

   // Every newly valid result comes from a second captured byte.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !$past(reset)) |-> $past(load_result))
      else $error("result produced without a second number byte");
`endif

endmodule
